[rtl/hptm_pkg.sv]
// ----------------------------------------------------------------------------
// hptm_pkg
// Shared types and constants of the hot page table with min-count replacement.
// ----------------------------------------------------------------------------
package hptm_pkg;

	localparam int CAPACITY = 512;
	localparam int IDX_W    = $clog2(CAPACITY);

	localparam int KIND_W  = 2;
	localparam int ADDR_W  = 48;
	localparam int COUNT_W = 15;
	localparam int SLOT_W  = 9;
	localparam int ACT_W   = 3;
	localparam int OCC_W   = 10;

	localparam int CMDQ_DEPTH = 2;

	// input kinds
	localparam logic [KIND_W-1:0] KIND_RECORD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

	// result actions
	localparam logic [ACT_W-1:0] ACT_UPDATED  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_INSERTED = 3'd1;
	localparam logic [ACT_W-1:0] ACT_REPLACED = 3'd2;
	localparam logic [ACT_W-1:0] ACT_DROPPED  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_READ     = 3'd4;
	localparam logic [ACT_W-1:0] ACT_CLEARED  = 3'd5;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [ADDR_W-1:0]  page_address;
		logic [COUNT_W-1:0] page_count;
		logic [SLOT_W-1:0]  slot;
	} hptm_item_t;

	typedef struct packed {
		logic [ACT_W-1:0]   action;
		logic [SLOT_W-1:0]  entry_slot;
		logic [ADDR_W-1:0]  entry_address;
		logic [COUNT_W-1:0] entry_count;
		logic [OCC_W-1:0]   occupancy;
	} hptm_result_t;

	typedef enum logic [1:0] {
		OP_RECORD,
		OP_READ,
		OP_CLEAR,
		OP_NONE
	} hptm_op_t;

	typedef struct packed {
		hptm_op_t           op;
		logic [ADDR_W-1:0]  page_address;
		logic [COUNT_W-1:0] page_count;
		logic [SLOT_W-1:0]  slot;
	} hptm_cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [COUNT_W-1:0] count;
	} hptm_entry_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_RDWAIT
	} hptm_state_t;

endpackage

[rtl/hptm_front.sv]
// ----------------------------------------------------------------------------
// hptm_front
// Accepts input beats, decodes the kind into an operation and holds them in a
// short command queue for the table engine.
// ----------------------------------------------------------------------------
module hptm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  hptm_pkg::hptm_item_t item,
	input  logic                push,
	output logic                full,
	output hptm_pkg::hptm_cmd_t cmd,
	output logic                cmd_valid,
	input  logic                cmd_pop
);
	import hptm_pkg::*;

	localparam int PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

	hptm_cmd_t        slots_q [CMDQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	hptm_cmd_t        decoded;
	logic             do_push;

	always_comb begin
		decoded.page_address = item.page_address;
		decoded.page_count   = item.page_count;
		decoded.slot         = item.slot;
		case (item.kind)
			KIND_RECORD: decoded.op = OP_RECORD;
			KIND_READ:   decoded.op = OP_READ;
			KIND_CLEAR:  decoded.op = OP_CLEAR;
			default:     decoded.op = OP_NONE;
		endcase
	end

	assign full      = (count_q == CNT_W'(CMDQ_DEPTH));
	assign do_push   = push && !full;
	assign cmd_valid = (count_q != '0);
	assign cmd       = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (cmd_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !cmd_pop)
				count_q <= count_q + 1'b1;
			else if (!do_push && cmd_pop)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slots_q[wr_ptr_q] <= decoded;
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CMDQ_DEPTH))
		else $error("command queue over depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command popped from empty queue");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !cmd_pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("command queue count lost a beat");
`endif

endmodule

[rtl/hptm_engine.sv]
// ----------------------------------------------------------------------------
// hptm_engine
// Table engine: entry memory, fill level, scan for match and minimum count,
// and the result register toward the output side.
// ----------------------------------------------------------------------------
module hptm_engine (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hptm_pkg::hptm_cmd_t    cmd,
	input  logic                   cmd_valid,
	output logic                   cmd_pop,
	output hptm_pkg::hptm_result_t result,
	output logic                   empty,
	input  logic                   pop
);
	import hptm_pkg::*;

	hptm_entry_t mem [CAPACITY];
	hptm_entry_t mem_q;

	hptm_state_t state_q, state_d;
	logic [OCC_W-1:0] fill_q, fill_d;
	logic [OCC_W-1:0] rd_idx_q;
	logic             rd_pend_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [COUNT_W-1:0] best_q;
	logic [IDX_W-1:0] victim_q;

	logic         out_valid_q;
	hptm_result_t out_q;
	hptm_result_t res_d;
	logic         res_load;
	logic         out_ready;

	logic             mem_rd_en;
	logic [IDX_W-1:0] mem_rd_addr;
	logic             mem_wr_en;
	logic [IDX_W-1:0] mem_wr_addr;
	hptm_entry_t      mem_wr_data;

	logic scan_more;
	logic slot_in_range;

	assign out_ready     = !out_valid_q || pop;
	assign scan_more     = rd_idx_q < fill_q;
	assign slot_in_range = OCC_W'(cmd.slot) < fill_q;
	assign result        = out_q;
	assign empty         = !out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op)
						OP_RECORD: state_d = S_SCAN;
						OP_READ:   state_d = S_RDWAIT;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_SCAN: begin
				if (!scan_more && !rd_pend_s1)
					state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (out_ready)
					state_d = S_IDLE;
			end
			S_RDWAIT: begin
				if (out_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cmd_pop     = 1'b0;
		res_load    = 1'b0;
		res_d       = '0;
		fill_d      = fill_q;
		mem_rd_en   = 1'b0;
		mem_rd_addr = '0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = '0;
		mem_wr_data = '0;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op)
						OP_RECORD: ;
						OP_READ: begin
							mem_rd_en   = slot_in_range;
							mem_rd_addr = cmd.slot[IDX_W-1:0];
						end
						OP_CLEAR: begin
							if (out_ready) begin
								cmd_pop      = 1'b1;
								res_load     = 1'b1;
								fill_d       = '0;
								res_d.action = ACT_CLEARED;
							end
						end
						default: begin
							if (out_ready) begin
								cmd_pop         = 1'b1;
								res_load        = 1'b1;
								res_d.action    = ACT_DROPPED;
								res_d.occupancy = fill_q;
							end
						end
					endcase
				end
			end
			S_SCAN: begin
				mem_rd_en   = scan_more;
				mem_rd_addr = rd_idx_q[IDX_W-1:0];
			end
			S_DECIDE: begin
				if (out_ready) begin
					cmd_pop                = 1'b1;
					res_load               = 1'b1;
					mem_wr_data.addr       = cmd.page_address;
					mem_wr_data.count      = cmd.page_count;
					res_d.entry_address    = cmd.page_address;
					res_d.entry_count      = cmd.page_count;
					if (hit_q) begin
						mem_wr_en        = 1'b1;
						mem_wr_addr      = hit_idx_q;
						res_d.action     = ACT_UPDATED;
						res_d.entry_slot = SLOT_W'(hit_idx_q);
					end else if (fill_q < OCC_W'(CAPACITY)) begin
						mem_wr_en        = 1'b1;
						mem_wr_addr      = fill_q[IDX_W-1:0];
						fill_d           = fill_q + 1'b1;
						res_d.action     = ACT_INSERTED;
						res_d.entry_slot = SLOT_W'(fill_q);
					end else if (best_q < cmd.page_count) begin
						mem_wr_en        = 1'b1;
						mem_wr_addr      = victim_q;
						res_d.action     = ACT_REPLACED;
						res_d.entry_slot = SLOT_W'(victim_q);
					end else begin
						res_d.action        = ACT_DROPPED;
						res_d.entry_address = '0;
						res_d.entry_count   = '0;
					end
					res_d.occupancy = fill_d;
				end
			end
			S_RDWAIT: begin
				if (out_ready) begin
					cmd_pop          = 1'b1;
					res_load         = 1'b1;
					res_d.action     = ACT_READ;
					res_d.entry_slot = cmd.slot;
					res_d.occupancy  = fill_q;
					if (slot_in_range) begin
						res_d.entry_address = mem_q.addr;
						res_d.entry_count   = mem_q.count;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
			rd_idx_q    <= '0;
			rd_pend_s1  <= 1'b0;
			hit_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			if (res_load)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			if (state_q == S_SCAN) begin
				if (scan_more)
					rd_idx_q <= rd_idx_q + 1'b1;
				rd_pend_s1 <= scan_more;
				if (rd_pend_s1 && mem_q.addr == cmd.page_address)
					hit_q <= 1'b1;
			end else begin
				rd_idx_q   <= '0;
				rd_pend_s1 <= 1'b0;
				if (state_q == S_IDLE)
					hit_q <= 1'b0;
			end
		end
	end

	// scan datapath: entry data arrives in the cycle after its read
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN) begin
			rd_idx_s1 <= rd_idx_q[IDX_W-1:0];
			if (rd_pend_s1) begin
				if (mem_q.addr == cmd.page_address)
					hit_idx_q <= rd_idx_s1;
				// strict compare keeps the lowest slot on ties
				if (rd_idx_s1 == '0 || mem_q.count < best_q) begin
					best_q   <= mem_q.count;
					victim_q <= rd_idx_s1;
				end
			end
		end
		if (res_load)
			out_q <= res_d;
	end

	always_ff @(posedge clk) begin
		if (mem_wr_en)
			mem[mem_wr_addr] <= mem_wr_data;
		if (mem_rd_en)
			mem_q <= mem[mem_rd_addr];
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= OCC_W'(CAPACITY))
		else $error("fill level beyond capacity");
	a_write_in_decide: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr_en |-> (state_q == S_DECIDE && res_load))
		else $error("table written outside a record decision");
	a_pend_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> state_q == S_SCAN)
		else $error("scan read outstanding outside scan");
	a_pop_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> (res_load && cmd_valid))
		else $error("command retired without a result");
`endif

endmodule

[rtl/hot_page_table_min_replace.sv]
// ----------------------------------------------------------------------------
// hot_page_table_min_replace
// Bounded table of hot pages with minimum-count replacement.
// ----------------------------------------------------------------------------
// A record beat passes from idle through the scan state to the decide state in
// the engine: one entry memory read per stored entry covers both the address
// match and the minimum count search.
// A read beat issues a registered memory read, then retires; a clear retires from idle.
// A two-beat command queue keeps taking input while the engine scans, until full.
// Reset is asynchronous, active low; it empties the table, the command queue and the result register.
module hot_page_table_min_replace (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hptm_pkg::hptm_item_t   item,
	input  logic                   push,
	output logic                   full,
	output hptm_pkg::hptm_result_t result,
	output logic                   empty,
	input  logic                   pop
);
	import hptm_pkg::*;

	hptm_cmd_t cmd;
	logic      cmd_valid;
	logic      cmd_pop;

	hptm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.push      (push),
		.full      (full),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop)
	);

	hptm_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

[verif/tb_hot_page_table_min_replace.sv]
// ----------------------------------------------------------------------------
// tb_hot_page_table_min_replace
// Self-checking bench for the hot page table: a scoreboard keeps its own copy
// of the table, predicts every result beat and compares it field by field.
// Directed beats cover field extremes and each operation, then random traffic
// runs a small-table phase, a fill to capacity and a replacement phase.
// ----------------------------------------------------------------------------
module tb_hot_page_table_min_replace;
	timeunit 1ns;
	timeprecision 1ps;

	import hptm_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 6000000;
	localparam int DRAIN_CYCLES = 600;

	class page_table_scoreboard;
		logic [ADDR_W-1:0]  page_addr [CAPACITY];
		logic [COUNT_W-1:0] page_cnt [CAPACITY];
		int                 fill;
		hptm_result_t       outcome_q [$];
		int                 errors;

		function new();
			fill = 0;
			errors = 0;
		endfunction

		function int pending_count();
			return outcome_q.size();
		endfunction

		// updates the table copy for one accepted beat and queues its result
		function void apply_item(hptm_item_t it);
			hptm_result_t       r;
			int                 hit;
			int                 victim;
			logic [COUNT_W-1:0] best;
			r = '0;
			case (it.kind)
				KIND_RECORD: begin
					hit = -1;
					for (int i = 0; i < fill; i++)
						if (page_addr[i] == it.page_address)
							hit = i;
					if (hit >= 0) begin
						page_cnt[hit] = it.page_count;
						r.action = ACT_UPDATED;
						r.entry_slot = hit[SLOT_W-1:0];
						r.entry_address = it.page_address;
						r.entry_count = it.page_count;
					end else if (fill < CAPACITY) begin
						page_addr[fill] = it.page_address;
						page_cnt[fill] = it.page_count;
						r.action = ACT_INSERTED;
						r.entry_slot = fill[SLOT_W-1:0];
						r.entry_address = it.page_address;
						r.entry_count = it.page_count;
						fill++;
					end else begin
						// first slot holding the smallest count wins a tie
						victim = 0;
						best = page_cnt[0];
						for (int i = 1; i < fill; i++)
							if (page_cnt[i] < best) begin
								best = page_cnt[i];
								victim = i;
							end
						if (best < it.page_count) begin
							page_addr[victim] = it.page_address;
							page_cnt[victim] = it.page_count;
							r.action = ACT_REPLACED;
							r.entry_slot = victim[SLOT_W-1:0];
							r.entry_address = it.page_address;
							r.entry_count = it.page_count;
						end else begin
							r.action = ACT_DROPPED;
						end
					end
				end
				KIND_READ: begin
					r.action = ACT_READ;
					r.entry_slot = it.slot;
					if (int'(it.slot) < fill) begin
						r.entry_address = page_addr[it.slot];
						r.entry_count = page_cnt[it.slot];
					end
				end
				KIND_CLEAR: begin
					fill = 0;
					r.action = ACT_CLEARED;
				end
				default: begin
					r.action = ACT_DROPPED;
				end
			endcase
			r.occupancy = fill[OCC_W-1:0];
			outcome_q = {outcome_q, r};
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s expected 0x%0h actual 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(hptm_result_t got);
			hptm_result_t want;
			if (outcome_q.size() == 0) begin
				$error("result beat with no expectation waiting: 0x%0h", got);
				errors++;
				return;
			end
			want = outcome_q.pop_front();
			compare_field("action", 64'(want.action), 64'(got.action));
			compare_field("entry_slot", 64'(want.entry_slot), 64'(got.entry_slot));
			compare_field("entry_address", 64'(want.entry_address),
				64'(got.entry_address));
			compare_field("entry_count", 64'(want.entry_count), 64'(got.entry_count));
			compare_field("occupancy", 64'(want.occupancy), 64'(got.occupancy));
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	hptm_item_t   item;
	logic         push;
	logic         full;
	hptm_result_t result;
	logic         empty;
	logic         pop;

	page_table_scoreboard sb;
	int unsigned          cycles;
	int                   burst_left;

	hot_page_table_min_replace i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.push   (push),
		.full   (full),
		.result (result),
		.empty  (empty),
		.pop    (pop)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_result(result);
	end

	// receiver: randomly chosen stretches of steady pop, random pop and long stalls
	initial begin : receiver
		int mode;
		int len;
		forever begin
			mode = $urandom_range(0, 2);
			len = $urandom_range(20, 200);
			repeat (len) begin
				@(posedge clk);
				case (mode)
					0: pop <= 1'b1;
					1: pop <= 1'($urandom_range(0, 1));
					default: pop <= ($urandom_range(0, 29) == 0);
				endcase
			end
		end
	end

	function automatic logic [ADDR_W-1:0] rand_addr();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[ADDR_W-1:0];
	endfunction

	function automatic logic [COUNT_W-1:0] rand_count(int low_pct, int low_max);
		if ($urandom_range(0, 99) < low_pct)
			return COUNT_W'($urandom_range(0, low_max));
		return COUNT_W'($urandom_range(0, 32767));
	endfunction

	function automatic hptm_item_t build_item(logic [KIND_W-1:0] kind,
			logic [ADDR_W-1:0] addr, logic [COUNT_W-1:0] cnt, logic [SLOT_W-1:0] slot);
		hptm_item_t it;
		it.kind = kind;
		it.page_address = addr;
		it.page_count = cnt;
		it.slot = slot;
		return it;
	endfunction

	// unused fields of a beat carry random noise
	function automatic hptm_item_t noisy_item(logic [KIND_W-1:0] kind);
		return build_item(kind, rand_addr(), COUNT_W'($urandom_range(0, 32767)),
			SLOT_W'($urandom_range(0, 511)));
	endfunction

	function automatic hptm_item_t noisy_read(int max_slot);
		hptm_item_t it;
		it = noisy_item(KIND_READ);
		it.slot = SLOT_W'($urandom_range(0, max_slot));
		return it;
	endfunction

	// sender: bursts of back-to-back beats separated by random gaps
	task automatic send_item(hptm_item_t it);
		int gap;
		int pick;
		if (burst_left == 0) begin
			pick = $urandom_range(0, 99);
			burst_left = (pick < 10) ? 150 : $urandom_range(1, 40);
			if (pick < 70)
				gap = $urandom_range(1, 4);
			else if (pick < 95)
				gap = $urandom_range(5, 60);
			else
				gap = $urandom_range(100, 600);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		item <= it;
		push <= 1'b1;
		do @(posedge clk); while (full);
		sb.apply_item(it);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (sb.pending_count() != 0);
	endtask

	initial begin : stimulus
		logic [ADDR_W-1:0] pool [24];
		logic [ADDR_W-1:0] ones;
		int                pick;
		int                s;

		clk = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		item = '0;
		cycles = 0;
		burst_left = 0;
		sb = new();
		ones = '1;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every operation, empty and out-of-range reads
		send_item(build_item(KIND_READ, ones, '1, 9'd0));
		send_item(build_item(KIND_RECORD, '0, '0, '0));
		send_item(build_item(KIND_RECORD, ones, '1, ones[SLOT_W-1:0]));
		send_item(build_item(KIND_RECORD, '0, '1, '0));
		send_item(build_item(KIND_RECORD, ones, '0, '0));
		send_item(build_item(KIND_RECORD, 48'h5555_5555_5555, 15'h2aaa, 9'h155));
		send_item(build_item(KIND_RECORD, 48'haaaa_aaaa_aaaa, 15'h5555, 9'h0aa));
		for (int i = 0; i < 4; i++)
			send_item(build_item(KIND_READ, '0, '0, SLOT_W'(i)));
		send_item(build_item(KIND_READ, '0, '0, 9'd4));
		send_item(build_item(KIND_READ, ones, '1, '1));
		send_item(build_item(KIND_UNUSED, ones, '1, '1));
		send_item(build_item(KIND_CLEAR, ones, '1, '1));
		send_item(build_item(KIND_READ, '0, '0, 9'd0));
		send_item(build_item(KIND_CLEAR, '0, '0, '0));
		send_item(build_item(KIND_RECORD, 48'h0000_1234_5000, 15'd77, '1));
		send_item(build_item(KIND_READ, '0, '0, 9'd0));
		wait_drained();

		// small table: a shared address pool makes hits frequent
		pool[0] = '0;
		pool[1] = ones;
		for (int i = 2; i < 24; i++)
			pool[i] = rand_addr();
		for (int n = 0; n < 250; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				send_item(build_item(KIND_RECORD, pool[$urandom_range(0, 23)],
					COUNT_W'($urandom_range(0, 32767)), SLOT_W'($urandom_range(0, 511))));
			else if (pick < 65)
				send_item(build_item(KIND_RECORD, rand_addr(),
					COUNT_W'($urandom_range(0, 32767)), SLOT_W'($urandom_range(0, 511))));
			else if (pick < 80)
				send_item(noisy_read(31));
			else if (pick < 90)
				send_item(noisy_read(511));
			else if (pick < 95)
				send_item(noisy_item(KIND_CLEAR));
			else
				send_item(noisy_item(KIND_UNUSED));
		end
		wait_drained();

		// fill to capacity with mostly tiny counts so minimum ties are common
		send_item(noisy_item(KIND_CLEAR));
		while (sb.fill < CAPACITY) begin
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				send_item(noisy_read(511));
			end else if (pick < 10 && sb.fill > 0) begin
				s = $urandom_range(0, sb.fill - 1);
				send_item(build_item(KIND_RECORD, sb.page_addr[s], rand_count(80, 3),
					SLOT_W'($urandom_range(0, 511))));
			end else begin
				send_item(build_item(KIND_RECORD, rand_addr(), rand_count(80, 3),
					SLOT_W'($urandom_range(0, 511))));
			end
		end
		wait_drained();

		// full table: replacements, drops, updates that move the minimum
		for (int n = 0; n < 330; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				send_item(build_item(KIND_RECORD, rand_addr(), rand_count(50, 15),
					SLOT_W'($urandom_range(0, 511))));
			end else if (pick < 70) begin
				s = $urandom_range(0, CAPACITY - 1);
				send_item(build_item(KIND_RECORD, sb.page_addr[s], rand_count(50, 7),
					SLOT_W'($urandom_range(0, 511))));
			end else if (pick < 95) begin
				send_item(noisy_read(511));
			end else begin
				send_item(noisy_item(KIND_UNUSED));
			end
		end
		send_item(noisy_item(KIND_CLEAR));
		send_item(noisy_read(511));

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending_count() != 0)
			$error("%0d expected result beats never arrived", sb.pending_count());
		if (sb.errors == 0 && sb.pending_count() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
